// ----- rtl/core/tsre_pkg.sv -----
package tsre_pkg;

  // Longest scanline the encoder is sized for.
  localparam int MAX_LINE_WIDTH = 1024;

  // Width of the run counter.
  localparam int RUN_W = 11;

  localparam int CLEAR_LIMIT_RAW = (MAX_LINE_WIDTH > 0) ? MAX_LINE_WIDTH - 1 : 0;
  localparam int CLEAR_LIMIT = (CLEAR_LIMIT_RAW > (1 << RUN_W) - 1) ?
                               (1 << RUN_W) - 1 : CLEAR_LIMIT_RAW;

  localparam int CLEAR_SPLIT = 254;
  localparam int OPAQUE_MAX  = 255;

  // Number of (254, 0) pairs a saturated clear run can need.
  localparam int MAX_PAIRS = (CLEAR_LIMIT > CLEAR_SPLIT) ? (CLEAR_LIMIT - 1) / CLEAR_SPLIT : 0;
  localparam int PAIR_W    = (MAX_PAIRS > 0) ? $clog2(MAX_PAIRS + 1) : 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CODE_ZERO  = 8'd0;
  localparam logic [7:0] CODE_SPLIT = 8'd254;
  localparam logic [7:0] CODE_MAX   = 8'd255;
  localparam logic [7:0] CODE_EOL   = 8'd255;

  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // One classified input item, as handed from the front end to the emitter.
  typedef struct packed {
    logic [PAIR_W-1:0] pairs;   // leading (254, 0) pairs
    logic              split;   // (255, 0) for an opaque run that overflowed
    logic              has_a;   // code before the pixel
    logic [7:0]        code_a;
    logic              has_px;
    logic [7:0]        pixel;
    logic [7:0]        code_b;  // opaque count closing the line
    logic              eol;
  } tsre_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tsre_fifo_stat_t;

endpackage

// ----- rtl/core/tsre_fifo.sv -----
module tsre_fifo
  import tsre_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tsre_cmd_t       push_cmd,
  input  logic            pop,
  output tsre_cmd_t       head,
  output tsre_fifo_stat_t stat
);

  tsre_cmd_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  assign stat.full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/tsre_front.sv -----
module tsre_front
  import tsre_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // pixel[7:0]
  input  logic            in_tlast,   // line_end
  input  tsre_fifo_stat_t fifo_stat,
  output logic            push,
  output tsre_cmd_t       push_cmd
);

  logic              opq_r,   opq_nxt;
  logic [RUN_W-1:0]  run_r,   run_nxt;
  logic [7:0]        rem_r,   rem_nxt;    // clear run length left over after the 254 splits
  logic [PAIR_W-1:0] pairs_r, pairs_nxt;
  logic              accept;
  logic              quiet;
  logic [RUN_W-1:0]  new_len;

  assign in_tready = !fifo_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && !quiet;

  always_comb begin
    opq_nxt   = opq_r;
    run_nxt   = run_r;
    rem_nxt   = rem_r;
    pairs_nxt = pairs_r;
    push_cmd  = '0;
    quiet     = 1'b0;
    new_len   = '0;

    if (in_tdata == 8'd0) begin
      if (opq_r) begin
        push_cmd.has_a  = 1'b1;
        push_cmd.code_a = run_r[7:0];
        opq_nxt         = 1'b0;
        run_nxt         = RUN_W'(1);
        rem_nxt         = 8'd1;
        pairs_nxt       = '0;
      end else if (run_r < RUN_W'(CLEAR_LIMIT)) begin
        run_nxt = run_r + 1'b1;
        // The remainder stays in 1..254 once the run is non-empty.
        if (rem_r == CODE_SPLIT) begin
          rem_nxt   = 8'd1;
          pairs_nxt = pairs_r + 1'b1;
        end else begin
          rem_nxt = rem_r + 1'b1;
        end
      end
      push_cmd.eol = in_tlast;
      quiet        = !opq_r && !in_tlast;
    end else begin
      if (!opq_r) begin
        push_cmd.pairs  = pairs_r;
        push_cmd.has_a  = 1'b1;
        push_cmd.code_a = rem_r;
        new_len         = RUN_W'(1);
      end else if (run_r >= RUN_W'(OPAQUE_MAX)) begin
        push_cmd.split = 1'b1;
        new_len        = RUN_W'(1);
      end else begin
        new_len = run_r + 1'b1;
      end
      opq_nxt         = 1'b1;
      run_nxt         = new_len;
      push_cmd.has_px = 1'b1;
      push_cmd.pixel  = in_tdata;
      push_cmd.code_b = new_len[7:0];
      push_cmd.eol    = in_tlast;
    end

    if (in_tlast) begin
      opq_nxt   = 1'b0;
      run_nxt   = '0;
      rem_nxt   = '0;
      pairs_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opq_r   <= 1'b0;
      run_r   <= '0;
      rem_r   <= '0;
      pairs_r <= '0;
    end else if (accept) begin
      opq_r   <= opq_nxt;
      run_r   <= run_nxt;
      rem_r   <= rem_nxt;
      pairs_r <= pairs_nxt;
    end
  end

endmodule

// ----- rtl/core/tsre_back.sv -----
module tsre_back
  import tsre_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  tsre_cmd_t       head,
  input  tsre_fifo_stat_t fifo_stat,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,   // value[7:0]
  output logic [1:0]      out_tuser,   // kind[0], line_done[1]
  output logic            out_tlast    // last
);

  // One bit per part of an item's result sequence, in emission order.
  localparam logic [5:0] PH_PAIRS = 6'b000001;
  localparam logic [5:0] PH_SPLIT = 6'b000010;
  localparam logic [5:0] PH_A     = 6'b000100;
  localparam logic [5:0] PH_PIX   = 6'b001000;
  localparam logic [5:0] PH_B     = 6'b010000;
  localparam logic [5:0] PH_EOL   = 6'b100000;

  logic [5:0]        done_r, done_nxt;
  logic              half_r, half_nxt;
  logic [PAIR_W-1:0] pcnt_r, pcnt_nxt;
  logic              out_valid_r;
  logic [7:0]        out_val_r;
  logic              out_kind_r;
  logic              out_done_r;
  logic              out_last_r;

  logic [5:0]        en;
  logic [5:0]        pend;
  logic [5:0]        cur_oh;
  logic [5:0]        pend_after;
  logic              adv;
  logic              fire;
  logic              completes;
  logic              last;
  logic              r_kind;
  logic [7:0]        r_val;
  logic              r_done;

  assign en = {head.eol, head.has_px & head.eol, head.has_px, head.has_a,
               head.split, (head.pairs != '0)};
  assign pend   = en & ~done_r;
  assign cur_oh = pend & (~pend + 6'd1);

  assign adv  = !out_valid_r || out_tready;
  assign fire = adv && !fifo_stat.empty;

  always_comb begin
    r_kind    = KIND_CODE;
    r_val     = CODE_ZERO;
    r_done    = 1'b0;
    completes = 1'b1;
    unique case (cur_oh)
      PH_PAIRS: begin
        r_val     = half_r ? CODE_ZERO : CODE_SPLIT;
        completes = half_r && (PAIR_W'(pcnt_r + 1'b1) == head.pairs);
      end
      PH_SPLIT: begin
        r_val     = half_r ? CODE_ZERO : CODE_MAX;
        completes = half_r;
      end
      PH_A: begin
        r_val = head.code_a;
      end
      PH_PIX: begin
        r_kind = KIND_PIXEL;
        r_val  = head.pixel;
      end
      PH_B: begin
        r_val = head.code_b;
      end
      PH_EOL: begin
        r_val  = CODE_EOL;
        r_done = 1'b1;
      end
      default: begin
        completes = 1'b1;
      end
    endcase
  end

  assign pend_after = completes ? (pend & ~cur_oh) : pend;
  assign last       = (pend_after == '0);
  assign pop        = fire && last;

  always_comb begin
    done_nxt = done_r;
    half_nxt = half_r;
    pcnt_nxt = pcnt_r;
    if (fire) begin
      if (last) begin
        done_nxt = '0;
        half_nxt = 1'b0;
        pcnt_nxt = '0;
      end else if (completes) begin
        done_nxt = done_r | cur_oh;
        half_nxt = 1'b0;
        pcnt_nxt = '0;
      end else begin
        half_nxt = !half_r;
        if ((cur_oh == PH_PAIRS) && half_r) begin
          pcnt_nxt = pcnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      half_r      <= 1'b0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      half_r <= half_nxt;
      pcnt_r <= pcnt_nxt;
      if (adv) begin
        out_valid_r <= !fifo_stat.empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_val_r  <= r_val;
      out_kind_r <= r_kind;
      out_done_r <= r_done;
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = {out_done_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/transparent_sprite_rle_encoder.sv -----
// Run-length encoder for sprites with a transparent color (pixel value 0).
//
// Input stream: one 8-bit pixel per item in in_tdata, in raster order, with
// in_tlast high on the last pixel of each scanline. Output stream: one byte
// per item in out_tdata; out_tuser[0] is high for a passed-through opaque
// pixel and low for a control code, out_tuser[1] marks the end-of-line code
// 255, and out_tlast marks the last result byte caused by an input pixel.
// A clear pixel in the middle of a clear run produces no output at all.
//
// The front end classifies each pixel and updates the run state in the
// cycle it is accepted, so it takes one pixel per clock as long as its
// four-entry command queue has room. The emitter drains the queue at one
// result byte per clock while out_tready is high; a pixel causes at most
// 12 result bytes at the default line width. A pixel's command is first
// written into the queue, then its first result into the output register.
//
// When the receiver holds out_tready low, the output register holds its
// byte, the queue fills, and in_tready drops once it is full. Reset empties
// the queue and the output register and starts a clear run of length zero.
module transparent_sprite_rle_encoder
  import tsre_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // pixel[7:0]
  input  logic       in_tlast,    // line_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // value[7:0]
  output logic [1:0] out_tuser,   // kind[0], line_done[1]
  output logic       out_tlast    // last
);

  tsre_fifo_stat_t fifo_stat;
  tsre_cmd_t       push_cmd;
  tsre_cmd_t       head;
  logic            push;
  logic            pop;

  tsre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tsre_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  tsre_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .fifo_stat  (fifo_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The end-of-line code is always 255 and always the final byte of its item.
  a_eol_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && (out_tdata == CODE_EOL) && !out_tuser[0])
    else $error("end-of-line code malformed");

  // Passed-through pixels are never transparent.
  a_pixel_opaque : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata != 8'd0))
    else $error("transparent pixel emitted as opaque");

  // The queue can never report full and empty at once.
  a_fifo_stat : assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("command queue status inconsistent");

  // Nothing is offered in the cycle after reset.
  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
